// File: hw/rtl/hfpq_pkg.sv
// Shared types and constants of the hierarchical FIFO priority queue.
`default_nettype none

package hfpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int POINT_W  = 24;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // operation codes on the input tuser
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_POP   = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [POINT_W-1:0] point;
    } t_entry;

    typedef struct packed {
        t_kind              kind;
        logic [LEVEL_W-1:0] level;
        logic [POINT_W-1:0] point;
    } t_cmd;

endpackage

`default_nettype wire

// File: hw/rtl/hfpq_cell.sv
// One queue cell: holds one entry and trades it with its neighbors.
`default_nettype none

module hfpq_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hfpq_pkg::t_cmd    i_cmd,
    input  wire hfpq_pkg::t_entry  i_left,
    input  wire hfpq_pkg::t_entry  i_right,
    output hfpq_pkg::t_entry       o_entry,
    output hfpq_pkg::t_entry       o_next
);

    logic                        r_valid;
    logic [hfpq_pkg::LEVEL_W-1:0] r_level;
    logic [hfpq_pkg::POINT_W-1:0] r_point;
    hfpq_pkg::t_entry            n_entry;
    hfpq_pkg::t_entry            w_own;
    logic                        w_left_le;
    logic                        w_own_gt;

    assign w_own = '{valid: r_valid, level: r_level, point: r_point};

    always_comb begin
        w_left_le = i_left.valid && (i_left.level <= i_cmd.level);
        w_own_gt  = !r_valid || (r_level > i_cmd.level);
        n_entry   = w_own;
        case (i_cmd.kind)
            hfpq_pkg::KIND_FLUSH: begin
                n_entry.valid = 1'b0;
            end
            hfpq_pkg::KIND_POP: begin
                // advance toward the head
                n_entry = i_right;
            end
            hfpq_pkg::KIND_PUSH: begin
                // insert after every entry of equal or lower level
                if (w_left_le && w_own_gt) begin
                    n_entry = '{valid: 1'b1, level: i_cmd.level, point: i_cmd.point};
                end else if (!w_left_le) begin
                    n_entry = i_left;
                end
            end
            default: begin
                n_entry = w_own;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_level <= n_entry.level;
        r_point <= n_entry.point;
    end

    assign o_entry = w_own;
    assign o_next  = n_entry;

endmodule

`default_nettype wire

// File: hw/rtl/hfpq_chain.sv
// Row of queue cells kept sorted by level, arrival order within a level.
`default_nettype none

module hfpq_chain (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire hfpq_pkg::t_cmd  i_cmd,
    output hfpq_pkg::t_entry     o_head,
    output hfpq_pkg::t_entry     o_head_next
);

    hfpq_pkg::t_entry w_entry [hfpq_pkg::CAPACITY];
    hfpq_pkg::t_entry w_next  [hfpq_pkg::CAPACITY];

    for (genvar g = 0; g < hfpq_pkg::CAPACITY; g++) begin : g_cell
        hfpq_pkg::t_entry w_left;
        hfpq_pkg::t_entry w_right;

        if (g == 0) begin : g_first
            // level zero sentinel ahead of the head: a push may always land behind it
            assign w_left = '{valid: 1'b1, level: '0, point: '0};
        end else begin : g_mid
            assign w_left = w_entry[g-1];
        end

        if (g == hfpq_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_entry[g+1];
        end

        hfpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_next  (w_next[g])
        );
    end

    assign o_head      = w_entry[0];
    assign o_head_next = w_next[0];

endmodule

`default_nettype wire

// File: hw/rtl/hierarchical_fifo_priority_queue.sv
// Hierarchical FIFO priority queue: a sorted row of cells behind a command register.
// An accepted transaction is decoded against the count and registered; in the cycle
// after, every cell of the row updates in parallel and the result is loaded into the
// output register. No new transaction is taken while busy or while the output stalls.
// Reset (synchronous, active low) clears all cell valid bits and the count at once,
// so the queue is empty and ready in the cycle after reset is released.
`default_nettype none

module hierarchical_fifo_priority_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // point[23:0], level[31:24]
    input  wire logic [1:0]  i_s_axis_tuser,  // operation[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [71:0]      o_m_axis_tdata,  // popped_point[23:0], front_point[47:24],
                                              // current_level[55:48], empty_res[56],
                                              // count[67:57], zero[71:68]
    output logic [1:0]       o_m_axis_tuser   // status[1:0]
);

    logic                          w_accept;
    logic                          r_busy;
    hfpq_pkg::t_cmd                r_cmd;
    hfpq_pkg::t_cmd                n_cmd;
    hfpq_pkg::t_status             r_status;
    hfpq_pkg::t_status             n_status;
    logic [hfpq_pkg::COUNT_W-1:0]  r_count;
    logic [hfpq_pkg::COUNT_W-1:0]  n_count;
    logic                          r_out_valid;
    logic [71:0]                   r_out_data;
    logic [1:0]                    r_out_user;
    logic [71:0]                   n_out_data;
    hfpq_pkg::t_cmd                w_chain_cmd;
    hfpq_pkg::t_entry              w_head;
    hfpq_pkg::t_entry              w_head_next;
    logic [hfpq_pkg::POINT_W-1:0]  w_popped;
    logic [hfpq_pkg::POINT_W-1:0]  w_front;
    logic [hfpq_pkg::LEVEL_W-1:0]  w_level;

    assign o_s_axis_tready = !r_busy && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // decode the transaction against the current count
    always_comb begin
        n_cmd.point = i_s_axis_tdata[23:0];
        n_cmd.level = i_s_axis_tdata[31:24];
        n_cmd.kind  = hfpq_pkg::KIND_NONE;
        n_status    = hfpq_pkg::ST_OK;
        case (i_s_axis_tuser)
            hfpq_pkg::OP_PUSH: begin
                if (r_count == hfpq_pkg::COUNT_W'(hfpq_pkg::CAPACITY)) begin
                    n_status = hfpq_pkg::ST_FULL;
                end else begin
                    n_cmd.kind = hfpq_pkg::KIND_PUSH;
                end
            end
            hfpq_pkg::OP_POP: begin
                if (r_count == '0) begin
                    n_status = hfpq_pkg::ST_EMPTY;
                end else begin
                    n_cmd.kind = hfpq_pkg::KIND_POP;
                end
            end
            hfpq_pkg::OP_FLUSH: begin
                n_cmd.kind = hfpq_pkg::KIND_FLUSH;
            end
            default: begin
                n_cmd.kind = hfpq_pkg::KIND_NONE;
            end
        endcase
    end

    // the row only moves in the cycle that executes a command
    always_comb begin
        w_chain_cmd = r_cmd;
        if (!r_busy) begin
            w_chain_cmd.kind = hfpq_pkg::KIND_NONE;
        end
    end

    hfpq_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_chain_cmd),
        .o_head      (w_head),
        .o_head_next (w_head_next)
    );

    always_comb begin
        n_count = r_count;
        case (r_cmd.kind)
            hfpq_pkg::KIND_PUSH:  n_count = r_count + hfpq_pkg::COUNT_W'(1);
            hfpq_pkg::KIND_POP:   n_count = r_count - hfpq_pkg::COUNT_W'(1);
            hfpq_pkg::KIND_FLUSH: n_count = '0;
            default:              n_count = r_count;
        endcase
        w_popped = (r_cmd.kind == hfpq_pkg::KIND_POP) ? w_head.point : '0;
        w_front  = w_head_next.valid ? w_head_next.point : '0;
        w_level  = w_head_next.valid ? w_head_next.level : '0;
        n_out_data = {4'b0, n_count, (n_count == '0), w_level, w_front, w_popped};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= n_cmd;
            r_status <= n_status;
        end
        if (r_busy) begin
            r_out_data <= n_out_data;
            r_out_user <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire
